[rtl/core/tensor_index_linearizer_macros.svh]
// ----------------------------------------------------------------------------
// Tensor index linearizer assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TENSOR_INDEX_LINEARIZER_MACROS_SVH
`define TENSOR_INDEX_LINEARIZER_MACROS_SVH

// Property checked at every rising edge outside reset
`define TIL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition in one cycle implies a property in the next cycle
`define TIL_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/tidx_pkg.sv]
// ----------------------------------------------------------------------------
// Tensor index linearizer package
// Widths, register indexes and pipeline types shared by the block.
// ----------------------------------------------------------------------------
package tidx_pkg;

    localparam int OFFSET_W   = 48;
    localparam int COORD_W    = 12;
    localparam int EXT_W      = 13;
    localparam int RANK_W     = 3;
    localparam int FIELD_DIMS = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Restoring divider: bits retired per pipeline stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = OFFSET_W / DIV_BITS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_3 = 3'd4;

    typedef logic [FIELD_DIMS-1:0][EXT_W-1:0]   ext_vec_t;
    typedef logic [FIELD_DIMS-1:0][COORD_W-1:0] coord_vec_t;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic [RANK_W-1:0] used;
        ext_vec_t          ext;
    } cfg_t;

    // One item in flight
    typedef struct packed {
        logic                valid;
        logic                mode;
        logic                err;
        logic [OFFSET_W-1:0] quot;
        logic [EXT_W-1:0]    rem;
        logic [OFFSET_W-1:0] offset;
        coord_vec_t          cin;
        coord_vec_t          cres;
    } pipe_t;

endpackage

[rtl/core/tidx_cfg.sv]
// ----------------------------------------------------------------------------
// Tensor index linearizer configuration
// Rank and extent registers, with rank clamping and extent capping.
// ----------------------------------------------------------------------------
module tidx_cfg #(
    parameter int MAX_DIMS    = 4,
    parameter int EXTENT_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [tidx_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [tidx_pkg::CFG_DATA_W-1:0]  wr_data,
    output tidx_pkg::cfg_t                   eff
);

    localparam int LIMIT = (MAX_DIMS < tidx_pkg::FIELD_DIMS) ? MAX_DIMS : tidx_pkg::FIELD_DIMS;
    localparam int CAPI  = (EXTENT_BITS < tidx_pkg::EXT_W) ? (1 << EXTENT_BITS)
                                                          : ((1 << tidx_pkg::EXT_W) - 1);

    logic [tidx_pkg::RANK_W-1:0] rank_reg;
    tidx_pkg::ext_vec_t          ext_reg;
    logic [tidx_pkg::RANK_W-1:0] used;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= tidx_pkg::RANK_W'(1);
            for (int i = 0; i < tidx_pkg::FIELD_DIMS; i++)
            begin
                ext_reg[i] <= tidx_pkg::EXT_W'(1);
            end
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tidx_pkg::REG_RANK:  rank_reg   <= wr_data[tidx_pkg::RANK_W-1:0];
                tidx_pkg::REG_EXT_0: ext_reg[0] <= wr_data[tidx_pkg::EXT_W-1:0];
                tidx_pkg::REG_EXT_1: ext_reg[1] <= wr_data[tidx_pkg::EXT_W-1:0];
                tidx_pkg::REG_EXT_2: ext_reg[2] <= wr_data[tidx_pkg::EXT_W-1:0];
                tidx_pkg::REG_EXT_3: ext_reg[3] <= wr_data[tidx_pkg::EXT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp rank into 1..LIMIT
    always_comb
    begin
        used = rank_reg;
        if (rank_reg == '0)
        begin
            used = tidx_pkg::RANK_W'(1);
        end
        else if (rank_reg > tidx_pkg::RANK_W'(LIMIT))
        begin
            used = tidx_pkg::RANK_W'(LIMIT);
        end
    end

    // Unused dimensions act as extent 1; oversize extents are capped
    always_comb
    begin
        eff.used = used;
        for (int i = 0; i < tidx_pkg::FIELD_DIMS; i++)
        begin
            if (tidx_pkg::RANK_W'(i) >= used)
            begin
                eff.ext[i] = tidx_pkg::EXT_W'(1);
            end
            else if (ext_reg[i] > tidx_pkg::EXT_W'(CAPI))
            begin
                eff.ext[i] = tidx_pkg::EXT_W'(CAPI);
            end
            else
            begin
                eff.ext[i] = ext_reg[i];
            end
        end
    end

endmodule

[rtl/core/tidx_stage.sv]
// ----------------------------------------------------------------------------
// Tensor index linearizer pipeline stage
// Retires DIV_BITS quotient bits of one dimension's division; the first
// stage of each dimension also does one multiply-add step of the offset.
// ----------------------------------------------------------------------------
module tidx_stage #(
    parameter int DIM  = 0,
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  tidx_pkg::pipe_t              d,
    input  logic [tidx_pkg::EXT_W-1:0]   div_ext,
    input  logic [tidx_pkg::EXT_W-1:0]   mul_ext,
    output tidx_pkg::pipe_t              q
);

    tidx_pkg::pipe_t                                  n;
    tidx_pkg::pipe_t                                  data_reg;
    logic                                             valid_reg;
    logic [tidx_pkg::OFFSET_W+tidx_pkg::EXT_W-1:0]    prod;
    logic [tidx_pkg::EXT_W:0]                         trial;

    always_comb
    begin
        n     = d;
        prod  = '0;
        trial = '0;
        // Horner step, slowest dimension first
        if (STEP == 0)
        begin
            n.rem  = '0;
            prod   = d.offset * mul_ext;
            n.offset = prod[tidx_pkg::OFFSET_W-1:0]
                     + tidx_pkg::OFFSET_W'(d.cin[tidx_pkg::FIELD_DIMS-1-DIM]);
        end
        // Restoring division steps
        for (int k = 0; k < tidx_pkg::DIV_BITS; k++)
        begin
            trial  = {n.rem, n.quot[tidx_pkg::OFFSET_W-1]};
            n.quot = {n.quot[tidx_pkg::OFFSET_W-2:0], 1'b0};
            if (trial >= {1'b0, div_ext})
            begin
                trial     = trial - {1'b0, div_ext};
                n.quot[0] = 1'b1;
            end
            n.rem = trial[tidx_pkg::EXT_W-1:0];
        end
        // Remainder is this dimension's coordinate
        if (STEP == tidx_pkg::DIV_STEPS - 1)
        begin
            n.cres[DIM] = n.rem[tidx_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= n;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

[rtl/core/tensor_index_linearizer.sv]
// Pipeline: entry stage, then 4 x 12 divide/multiply-add stages, then the
//   output register.
// Throughput: one item per cycle while the output is not stalled; the 48-stage
//   restoring divider chain retires 4 quotient bits per stage, so every stage takes a new item.
// Reset: rank and all extents return to 1, pipeline valid bits clear.
// Config registers read live; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
// Tensor index linearizer
// Coordinate to linear offset (mode 0) and offset to coordinate (mode 1),
// dimension 0 fastest, with range checking.
// ----------------------------------------------------------------------------
`include "tensor_index_linearizer_macros.svh"

module tensor_index_linearizer #(
    parameter int MAX_DIMS    = 4,
    parameter int EXTENT_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coord_0, coord_1, coord_2, coord_3, lin_offset
    input  logic [0:0]  s_axis_tuser,   // mode
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // res_offset, res_coord_0..res_coord_3
    output logic [0:0]  m_axis_tuser    // range_error
);

    localparam int NSTAGE = tidx_pkg::FIELD_DIMS * tidx_pkg::DIV_STEPS;
    localparam int OW     = tidx_pkg::OFFSET_W;

    tidx_pkg::cfg_t       eff;
    logic                 adv;
    tidx_pkg::pipe_t      chain [0:NSTAGE];
    tidx_pkg::pipe_t      entry_next;
    logic                 entry_valid_reg;
    tidx_pkg::pipe_t      entry_reg;
    tidx_pkg::coord_vec_t cin;
    logic                 err_next;

    logic                 out_valid_reg;
    logic                 out_err_reg;
    logic                 out_mode_reg;
    logic [OW-1:0]        out_offset_reg;
    tidx_pkg::coord_vec_t out_coord_reg;
    logic                 fin_err;

    assign cfg_ready = 1'b1;

    tidx_cfg #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .eff      (eff)
    );

    // Whole pipeline moves when the output register is free or being drained
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Entry: mask unused coordinates, range check
    always_comb
    begin
        cin      = s_axis_tdata[47:0];
        err_next = 1'b0;
        for (int i = 0; i < tidx_pkg::FIELD_DIMS; i++)
        begin
            if (tidx_pkg::RANK_W'(i) >= eff.used)
            begin
                cin[i] = '0;
            end
            if (eff.ext[i] == '0)
            begin
                err_next = 1'b1;
            end
            if (!s_axis_tuser[0] && ({1'b0, cin[i]} >= eff.ext[i]))
            begin
                err_next = 1'b1;
            end
        end
        entry_next        = '0;
        entry_next.valid  = s_axis_tvalid;
        entry_next.mode   = s_axis_tuser[0];
        entry_next.err    = err_next;
        entry_next.quot   = s_axis_tdata[95:48];
        entry_next.cin    = cin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            entry_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entry_reg <= entry_next;
        end
    end

    always_comb
    begin
        chain[0]       = entry_reg;
        chain[0].valid = entry_valid_reg;
    end

    // Divide / multiply-add stages
    for (genvar g = 0; g < tidx_pkg::FIELD_DIMS; g++)
    begin : g_dim
        for (genvar s = 0; s < tidx_pkg::DIV_STEPS; s++)
        begin : g_step
            tidx_stage #(
                .DIM  (g),
                .STEP (s)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .d       (chain[g*tidx_pkg::DIV_STEPS + s]),
                .div_ext (eff.ext[g]),
                .mul_ext (eff.ext[tidx_pkg::FIELD_DIMS-1-g]),
                .q       (chain[g*tidx_pkg::DIV_STEPS + s + 1])
            );
        end
    end

    // Final check: offset must be fully consumed by the extents
    assign fin_err = chain[NSTAGE].err || (chain[NSTAGE].mode && (chain[NSTAGE].quot != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain[NSTAGE].valid;
        end
    end

    // Output register, data zeroed on error or for the unused direction
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_err_reg    <= fin_err;
            out_mode_reg   <= chain[NSTAGE].mode;
            out_offset_reg <= (fin_err || chain[NSTAGE].mode) ? '0 : chain[NSTAGE].offset;
            out_coord_reg  <= (fin_err || !chain[NSTAGE].mode) ? '0 : chain[NSTAGE].cres;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_coord_reg, out_offset_reg};
    assign m_axis_tuser[0] = out_err_reg;

    `TIL_ASSERT(a_err_zero, clk, rst_n, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0), "error result carries data")
    `TIL_ASSERT(a_stall_blocks_in, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while output stalled")
    `TIL_ASSERT(a_mode1_no_offset, clk, rst_n, (out_valid_reg && out_mode_reg) |-> (out_offset_reg == '0), "offset nonzero in mode 1")
    `TIL_ASSERT_NEXT(a_out_load, clk, rst_n, adv && chain[NSTAGE].valid, out_valid_reg, "pipeline result lost")

endmodule

[tb/sv/tb_tensor_index_linearizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tensor index linearizer testbench
// Drives coordinate and offset items through the stream ports over several
// rank/extent settings and idle mixes, predicting each result in a scoreboard.
// ----------------------------------------------------------------------------
module tb_tensor_index_linearizer;

    localparam int LATENCY   = 50;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [tidx_pkg::OFFSET_W-1:0] offset;
        tidx_pkg::coord_vec_t          coord;
        logic                          err;
    } conv_result_t;

    // Scoreboard: holds the config copy and the queue of expected conversions
    class conv_scoreboard;
        logic [tidx_pkg::RANK_W-1:0] rank_q;
        logic [tidx_pkg::EXT_W-1:0]  ext_q [tidx_pkg::FIELD_DIMS];
        conv_result_t                pending[$];
        int                          mismatches;
        int                          checked;

        function void clear_cfg();
            rank_q = tidx_pkg::RANK_W'(1);
            foreach (ext_q[i]) ext_q[i] = tidx_pkg::EXT_W'(1);
        endfunction

        function void write_reg(logic [tidx_pkg::CFG_IDX_W-1:0] idx,
                                logic [tidx_pkg::CFG_DATA_W-1:0] val);
            if (idx == tidx_pkg::REG_RANK) rank_q = val[tidx_pkg::RANK_W-1:0];
            else if (idx >= tidx_pkg::REG_EXT_0 && idx <= tidx_pkg::REG_EXT_3)
                ext_q[idx - tidx_pkg::REG_EXT_0] = val[tidx_pkg::EXT_W-1:0];
        endfunction

        // Column-major conversion with range check
        function void note_item(logic mode, tidx_pkg::coord_vec_t cin,
                                logic [tidx_pkg::OFFSET_W-1:0] lin);
            conv_result_t r;
            logic [63:0]  e [tidx_pkg::FIELD_DIMS];
            logic [63:0]  acc;
            logic [63:0]  c;
            logic [63:0]  md;
            int           used;
            r = '0;
            used = (rank_q < 1) ? 1 : (rank_q > 4) ? 4 : int'(rank_q);
            for (int i = 0; i < tidx_pkg::FIELD_DIMS; i++)
            begin
                e[i] = (i >= used) ? 64'd1 : (ext_q[i] > 4096) ? 64'd4096 : 64'(ext_q[i]);
                if (e[i] == 0) r.err = 1;
            end
            if (!r.err && !mode)
            begin
                acc = 0;
                for (int i = tidx_pkg::FIELD_DIMS - 1; i >= 0; i--)
                begin
                    c = (i < used) ? 64'(cin[i]) : 64'd0;
                    if (c >= e[i]) r.err = 1;
                    acc = acc * e[i] + c;
                end
                r.offset = acc[tidx_pkg::OFFSET_W-1:0];
            end
            else if (!r.err)
            begin
                acc = 64'(lin);
                for (int i = 0; i < tidx_pkg::FIELD_DIMS; i++)
                begin
                    md = acc % e[i];
                    r.coord[i] = md[tidx_pkg::COORD_W-1:0];
                    acc = acc / e[i];
                end
                if (acc != 0) r.err = 1;
            end
            if (r.err)
            begin
                r = '0;
                r.err = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(conv_result_t got);
            conv_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: off exp %h got %h, coord exp %h got %h, err exp %b got %b",
                        exp_r.offset, got.offset, exp_r.coord, got.coord, exp_r.err, got.err);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [12:0] cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = 0;   // coord_0, coord_1, coord_2, coord_3, lin_offset
    logic [0:0]  s_axis_tuser = 0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [95:0] m_axis_tdata;       // res_offset, res_coord_0..res_coord_3
    logic [0:0]  m_axis_tuser;       // range_error

    conv_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;
    int  cycle_cnt = 0;
    int  items_sent = 0;
    int  err_results = 0;

    tensor_index_linearizer dut (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: sample on rising edge, update ready on falling edge
    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result({m_axis_tdata[47:0], m_axis_tdata[95:48], m_axis_tuser[0]});
            if (m_axis_tuser[0]) err_results++;
        end

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_cfg(logic [2:0] idx, logic [12:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Waits for the pipeline to drain before touching registers
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_shape(int rk, int e0, int e1, int e2, int e3);
        drain();
        write_cfg(tidx_pkg::REG_RANK, 13'(rk));
        write_cfg(tidx_pkg::REG_EXT_0, 13'(e0));
        write_cfg(tidx_pkg::REG_EXT_1, 13'(e1));
        write_cfg(tidx_pkg::REG_EXT_2, 13'(e2));
        write_cfg(tidx_pkg::REG_EXT_3, 13'(e3));
    endtask

    task automatic send_item(logic mode, tidx_pkg::coord_vec_t c,
                             logic [tidx_pkg::OFFSET_W-1:0] lin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {lin, c};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(mode, c, lin);
        items_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_axis_tvalid <= 0;
    endtask

    // Mostly in-range items for the current shape, some out of range
    task automatic send_random();
        tidx_pkg::coord_vec_t          c;
        logic [tidx_pkg::OFFSET_W-1:0] lin;
        logic [63:0]                   vol;
        int                            used;
        int                            ext_i;
        used = (sb.rank_q < 1) ? 1 : (sb.rank_q > 4) ? 4 : int'(sb.rank_q);
        vol = 1;
        for (int i = 0; i < tidx_pkg::FIELD_DIMS; i++)
        begin
            c[i] = tidx_pkg::COORD_W'($urandom);
            if (i < used)
            begin
                ext_i = (sb.ext_q[i] > 4096) ? 4096 : int'(sb.ext_q[i]);
                vol = vol * 64'(ext_i);
                if ($urandom_range(9) < 8 && ext_i != 0)
                    c[i] = tidx_pkg::COORD_W'($urandom_range(ext_i - 1));
            end
        end
        lin = tidx_pkg::OFFSET_W'({$urandom, $urandom});
        if ($urandom_range(9) < 8 && vol != 0)
            lin = tidx_pkg::OFFSET_W'({$urandom, $urandom} % vol);
        send_item(1'($urandom_range(1)), c, lin);
    endtask

    initial
    begin
        sb = new();
        sb.clear_cfg();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: reset shape, full-range fields, every special case
        send_item(0, '0, 0);
        send_item(1, '0, 0);
        send_item(1, '0, 1);
        send_item(0, {4{12'hFFF}}, '1);
        end_burst();
        set_shape(4, 4096, 4096, 4096, 4096);
        send_item(0, {4{12'hFFF}}, 0);
        send_item(1, '0, '1);
        send_item(1, '0, 48'h5A5A_A5A5_3C3C);
        send_item(0, {12'h123, 12'hABC, 12'h555, 12'hAAA}, 0);
        end_burst();
        set_shape(2, 8191, 3, 4095, 0);      // extent above cap, unused zero
        send_item(0, {12'hFFF, 12'hFFF, 12'd2, 12'hFFF}, 0);
        send_item(0, {12'd0, 12'd0, 12'd3, 12'd0}, 0);
        send_item(1, '0, 48'd12287);
        send_item(1, '0, 48'd12288);
        end_burst();
        set_shape(0, 7, 5, 1, 1);            // rank zero acts as one
        send_item(0, {12'd0, 12'd0, 12'd4, 12'd6}, 0);
        send_item(1, '0, 48'd6);
        send_item(1, '0, 48'd7);
        end_burst();
        set_shape(7, 3, 0, 5, 6);            // rank above four, used zero extent
        send_item(0, '0, 0);
        send_item(1, '0, 0);
        end_burst();

        // Random phases over shapes and idle mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (ph == 7) set_shape(4, 4096, 4096, 4096, 4096);
            else set_shape($urandom_range(4), $urandom_range(1, 40), $urandom_range(1, 4096),
                           $urandom_range(1, 12), $urandom_range(8191));
            if (ph == 4) hold_off = 200;
            for (int k = 0; k < 55; k++) send_random();
            end_burst();
        end

        drain();
        $display("Sent %0d items over directed and 8 random phases; %0d results checked,",
                 items_sent, sb.checked);
        $display("%0d of them range errors, with a 200-cycle output hold-off.", err_results);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
